// File: rtl/bgi_pkg.sv
// Shared types and constants for the bilinear grid interpolator.
// No dependencies; imported by every module of the block.
package bgi_pkg;

  localparam int unsigned COMP_W  = 32;   // node and result component width
  localparam int unsigned CRD_W   = 32;   // coordinate / origin / scale width
  localparam int unsigned CELL_W  = 6;    // cell count width
  localparam int unsigned IDX_W   = 12;   // node_index port width
  localparam int unsigned ADDR_W  = 13;   // internal corner address width
  localparam int unsigned CFG_W   = 3;    // config register index width
  localparam int unsigned W_W     = 66;   // corner weight width (Q32.32)
  localparam int unsigned ACC_W   = 100;  // blend accumulator width
  localparam int unsigned FRAC_W  = 16;

  typedef enum logic [CFG_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_SCALE_X    = 3'd2,
    CFG_SCALE_Y    = 3'd3,
    CFG_CELLS_WIDE = 3'd4,
    CFG_CELLS_HIGH = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef logic [2:0][COMP_W-1:0] node_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] origin;
    logic [CRD_W-1:0]        scale;
    logic [CELL_W-1:0]       cells;
  } axis_cfg_t;

endpackage

// File: rtl/bgi_locate.sv
// Per-axis cell locator: coordinate to clamped cell index and Q16.16 remainder.
// Four register stages advanced by en_i. Depends on bgi_pkg.
module bgi_locate (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [bgi_pkg::CRD_W-1:0] coord_i,
  input  bgi_pkg::axis_cfg_t             cfg_i,
  output logic [bgi_pkg::CELL_W-1:0]     idx_o,
  output logic signed [31:0]             rem_o
);
  import bgi_pkg::*;

  logic signed [32:0] d_q, d_d;
  logic [32:0]        mag;
  logic [64:0]        p_q, p_d, p_rnd;
  logic               neg_q;
  logic signed [49:0] f;
  logic signed [57:0] s_q, s_d;
  logic [CELL_W-1:0]  n, nm1;
  logic signed [41:0] hi;
  logic [CELL_W-1:0]  idx_d, idx_q;
  logic signed [57:0] r;
  logic signed [31:0] rem_d, rem_q;

  assign n   = (cfg_i.cells == '0) ? CELL_W'(1) : cfg_i.cells;
  assign nm1 = n - CELL_W'(1);

  // stage 1: offset from origin
  assign d_d = 33'(coord_i) - 33'(cfg_i.origin);

  // stage 2: magnitude times scale
  assign mag = d_q[32] ? 33'(-d_q) : 33'(d_q);
  assign p_d = 65'(mag) * 65'(cfg_i.scale);

  // stage 3: floor to Q16.16, times cell count
  assign p_rnd = p_q + 65'd65535;
  assign f = neg_q ? -$signed({1'b0, p_rnd[64:FRAC_W]}) : $signed({1'b0, p_q[64:FRAC_W]});
  assign s_d = 58'(f) * 58'($signed({2'b0, n}));

  // stage 4: clamp index, saturate remainder
  assign hi = s_q[57:FRAC_W];
  always_comb begin
    if (hi < 0) begin
      idx_d = '0;
    end else if (hi > $signed(42'(nm1))) begin
      idx_d = nm1;
    end else begin
      idx_d = hi[CELL_W-1:0];
    end
    r = s_q - $signed(58'({idx_d, 16'h0}));
    if ((&r[57:31]) || !(|r[57:31])) begin
      rem_d = r[31:0];
    end else if (r[57]) begin
      rem_d = 32'sh8000_0000;
    end else begin
      rem_d = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= d_d;
      p_q   <= p_d;
      neg_q <= d_q[32];
      s_q   <= s_d;
      idx_q <= idx_d;
      rem_q <= rem_d;
    end
  end

  assign idx_o = idx_q;
  assign rem_o = rem_q;

endmodule

// File: rtl/bgi_node_mem.sv
// Grid node memory: one write port, two registered read ports.
// Out-of-range read addresses return zero. Depends on bgi_pkg.
module bgi_node_mem #(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [bgi_pkg::ADDR_W-1:0]  waddr_i,
  input  bgi_pkg::node_t              wdata_i,
  input  logic [bgi_pkg::ADDR_W-1:0]  raddr_i [2],
  output bgi_pkg::node_t              rdata_o [2]
);
  import bgi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);

  node_t mem_q [MAX_NODES];
  node_t rd_q [2];
  logic  ok_q [2];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[AW'(waddr_i)] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q[0] <= mem_q[AW'(raddr_i[0])];
      rd_q[1] <= mem_q[AW'(raddr_i[1])];
      ok_q[0] <= 32'(raddr_i[0]) < MAX_NODES;
      ok_q[1] <= 32'(raddr_i[1]) < MAX_NODES;
    end
  end

  assign rdata_o[0] = ok_q[0] ? rd_q[0] : '0;
  assign rdata_o[1] = ok_q[1] ? rd_q[1] : '0;

endmodule

// File: rtl/bgi_blend.sv
// Bilinear blend: corner weights, split products, adder tree, round and saturate.
// Five register stages advanced by en_i. Depends on bgi_pkg.
module bgi_blend (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [31:0]                rx_i,
  input  logic signed [31:0]                ry_i,
  input  bgi_pkg::node_t                    corner_i [4],
  output logic signed [bgi_pkg::COMP_W-1:0] interp_o [3]
);
  import bgi_pkg::*;

  localparam int unsigned SAT_LO = 32 + COMP_W - 1;

  logic signed [32:0]      wx0, wx1, wy0, wy1;
  logic signed [W_W-1:0]   w_q [4];
  logic signed [W_W-1:0]   pl_q [4][3];
  logic signed [W_W-1:0]   ph_q [4][3];
  logic signed [ACC_W-1:0] t_q [4][3];
  logic signed [ACC_W-1:0] sa_q [3];
  logic signed [ACC_W-1:0] sb_q [3];
  logic signed [ACC_W-1:0] acc_q [3];

  assign wx1 = 33'(rx_i);
  assign wy1 = 33'(ry_i);
  assign wx0 = 33'sd65536 - wx1;
  assign wy0 = 33'sd65536 - wy1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0] <= 66'(wx0) * 66'(wy0);
      w_q[1] <= 66'(wx0) * 66'(wy1);
      w_q[2] <= 66'(wx1) * 66'(wy0);
      w_q[3] <= 66'(wx1) * 66'(wy1);
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          pl_q[k][c] <= 66'($signed({1'b0, w_q[k][32:0]})) * 66'($signed(corner_i[k][c]));
          ph_q[k][c] <= 66'($signed(w_q[k][W_W-1:33])) * 66'($signed(corner_i[k][c]));
          t_q[k][c]  <= (ACC_W'(ph_q[k][c]) <<< 33) + ACC_W'(pl_q[k][c]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        sa_q[c]  <= t_q[0][c] + t_q[1][c];
        sb_q[c]  <= t_q[2][c] + t_q[3][c];
        acc_q[c] <= sa_q[c] + sb_q[c] + (ACC_W'(1) <<< 31);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if ((&acc_q[c][ACC_W-1:SAT_LO]) || !(|acc_q[c][ACC_W-1:SAT_LO])) begin
        interp_o[c] = acc_q[c][32+COMP_W-1:32];
      end else if (acc_q[c][ACC_W-1]) begin
        interp_o[c] = {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
        interp_o[c] = {1'b0, {(COMP_W-1){1'b1}}};
      end
    end
  end

endmodule

// File: rtl/bilinear_grid_interpolator.sv
// Bilinear grid interpolator top level: config registers, pipeline control, output skid.
// Throughput one word per cycle while the output skid is empty; a result held in the skid stalls input.
// Load words write the node memory at stage 6 and produce no result.
// The whole pipeline advances together; a one-word skid behind the output register
// lets input continue while a result waits. rst_ni clears valids and resets config registers to defaults.
module bilinear_grid_interpolator #(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bgi_pkg::CFG_W-1:0]          cfg_index_i,
  input  logic [31:0]                        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic [bgi_pkg::IDX_W-1:0]          node_index_i,
  input  logic signed [bgi_pkg::COMP_W-1:0]  node_x_i,
  input  logic signed [bgi_pkg::COMP_W-1:0]  node_y_i,
  input  logic signed [bgi_pkg::COMP_W-1:0]  node_z_i,
  input  logic signed [bgi_pkg::CRD_W-1:0]   coord_x_i,
  input  logic signed [bgi_pkg::CRD_W-1:0]   coord_y_i,
  input  logic                               last_query_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bgi_pkg::COMP_W-1:0]  interp_x_o,
  output logic signed [bgi_pkg::COMP_W-1:0]  interp_y_o,
  output logic signed [bgi_pkg::COMP_W-1:0]  interp_z_o,
  output logic                               last_result_o
);
  import bgi_pkg::*;

  localparam int unsigned NST = 10;

  axis_cfg_t cfg_x_q, cfg_y_q;

  logic en, pv, pop;
  logic [NST:1] qv_q;
  logic [5:1]   lv_q;
  logic [NST:1] last_q;
  logic [IDX_W-1:0] ld_idx_q [5:1];
  node_t            ld_node_q [5:1];

  logic [CELL_W-1:0]  xi, yi;
  logic signed [31:0] rx, ry, rx_q, ry_q;
  logic [CELL_W:0]    rows;
  logic [ADDR_W-1:0]  bl, tl_a, br_a, tr_a;
  logic [ADDR_W-1:0]  raddr_a [2], raddr_b [2];
  node_t              rd_a [2], rd_b [2], corner [4];
  logic               we;
  logic signed [COMP_W-1:0] blend [3];

  node_t              out_q, skid_q;
  logic               out_valid_q, skid_valid_q, out_last_q, skid_last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_x_q <= '{origin: '0, scale: 32'd65536, cells: CELL_W'(1)};
      cfg_y_q <= '{origin: '0, scale: 32'd65536, cells: CELL_W'(1)};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:   cfg_x_q.origin <= cfg_wdata_i;
        CFG_ORIGIN_Y:   cfg_y_q.origin <= cfg_wdata_i;
        CFG_SCALE_X:    cfg_x_q.scale  <= cfg_wdata_i;
        CFG_SCALE_Y:    cfg_y_q.scale  <= cfg_wdata_i;
        CFG_CELLS_WIDE: cfg_x_q.cells  <= cfg_wdata_i[CELL_W-1:0];
        CFG_CELLS_HIGH: cfg_y_q.cells  <= cfg_wdata_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= '0;
      lv_q <= '0;
    end else if (en) begin
      qv_q <= {qv_q[NST-1:1], in_valid_i && (command_i == CMD_QUERY)};
      lv_q <= {lv_q[4:1], in_valid_i && (command_i == CMD_LOAD)};
    end
  end

  // sideband and load payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q       <= {last_q[NST-1:1], last_query_i};
      ld_idx_q[1]  <= node_index_i;
      ld_node_q[1] <= {node_z_i, node_y_i, node_x_i};
      for (int s = 2; s <= 5; s++) begin
        ld_idx_q[s]  <= ld_idx_q[s-1];
        ld_node_q[s] <= ld_node_q[s-1];
      end
    end
  end

  bgi_locate u_loc_x (
    .clk_i(clk_i), .en_i(en), .coord_i(coord_x_i), .cfg_i(cfg_x_q),
    .idx_o(xi), .rem_o(rx)
  );

  bgi_locate u_loc_y (
    .clk_i(clk_i), .en_i(en), .coord_i(coord_y_i), .cfg_i(cfg_y_q),
    .idx_o(yi), .rem_o(ry)
  );

  // stage 5: corner addresses
  assign rows = ((cfg_y_q.cells == '0) ? (CELL_W+1)'(1) : (CELL_W+1)'(cfg_y_q.cells))
              + (CELL_W+1)'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      bl   <= ADDR_W'(xi) * ADDR_W'(rows) + ADDR_W'(yi);
      rx_q <= rx;
      ry_q <= ry;
    end
  end

  assign tl_a = bl + ADDR_W'(1);
  assign br_a = bl + ADDR_W'(rows);
  assign tr_a = br_a + ADDR_W'(1);

  assign raddr_a[0] = bl;
  assign raddr_a[1] = tl_a;
  assign raddr_b[0] = br_a;
  assign raddr_b[1] = tr_a;

  assign we = en && lv_q[5] && (32'(ld_idx_q[5]) < MAX_NODES);

  bgi_node_mem #(.MAX_NODES(MAX_NODES)) u_mem_a (
    .clk_i(clk_i), .en_i(en), .we_i(we), .waddr_i(ADDR_W'(ld_idx_q[5])),
    .wdata_i(ld_node_q[5]), .raddr_i(raddr_a), .rdata_o(rd_a)
  );

  bgi_node_mem #(.MAX_NODES(MAX_NODES)) u_mem_b (
    .clk_i(clk_i), .en_i(en), .we_i(we), .waddr_i(ADDR_W'(ld_idx_q[5])),
    .wdata_i(ld_node_q[5]), .raddr_i(raddr_b), .rdata_o(rd_b)
  );

  assign corner[0] = rd_a[0];
  assign corner[1] = rd_a[1];
  assign corner[2] = rd_b[0];
  assign corner[3] = rd_b[1];

  bgi_blend u_blend (
    .clk_i(clk_i), .en_i(en), .rx_i(rx_q), .ry_i(ry_q),
    .corner_i(corner), .interp_o(blend)
  );

  // output register and skid
  assign pv  = en && qv_q[NST];
  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= pv;
    end else if (pv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q      <= skid_q;
        out_last_q <= skid_last_q;
      end
    end else if (!out_valid_q || pop) begin
      out_q      <= {blend[2], blend[1], blend[0]};
      out_last_q <= last_q[NST];
    end else begin
      skid_q      <= {blend[2], blend[1], blend[0]};
      skid_last_q <= last_q[NST];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign interp_x_o    = out_q[0];
  assign interp_y_o    = out_q[1];
  assign interp_z_o    = out_q[2];
  assign last_result_o = out_last_q;

endmodule

// File: tb/tb_bilinear_grid_interpolator.sv
// Self-checking testbench for bilinear_grid_interpolator: directed table, then random
// grid loads and queries over several register settings. Depends on bgi_pkg and the RTL.
module tb_bilinear_grid_interpolator;
  import bgi_pkg::*;

  localparam int unsigned NODES = 4096;
  localparam int unsigned LIMIT = 400000;

  typedef struct {
    cmd_e        cmd;
    logic [11:0] idx;
    logic [31:0] nx, ny, nz, cx, cy;
    logic        last;
    bit          has_exp;
    logic [31:0] ex, ey, ez;
  } row_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
  } blend_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_index_i;
  logic [31:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o, command_i;
  logic [IDX_W-1:0] node_index_i;
  logic signed [COMP_W-1:0] node_x_i, node_y_i, node_z_i;
  logic signed [CRD_W-1:0] coord_x_i, coord_y_i;
  logic last_query_i, out_valid_o, out_ready_i;
  logic signed [COMP_W-1:0] interp_x_o, interp_y_o, interp_z_o;
  logic last_result_o;

  bilinear_grid_interpolator uut (.*);

  // predictor state
  logic [31:0] org_x, org_y, scl_x, scl_y;
  logic [5:0]  cells_w, cells_h;
  logic signed [31:0] node_mem [0:NODES-1][0:2];

  blend_t blend_q[$];
  int unsigned cycles, mismatches, results_seen, words_sent;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL bilinear_grid_interpolator");
      $finish;
    end
  end

  function automatic void locate_axis(input logic [31:0] crd, org, scl,
                                      input logic [5:0] cells,
                                      output int unsigned idx, output longint rem);
    longint d, f, s, i, n;
    logic [63:0] mag;
    logic [127:0] p;
    d = longint'($signed(crd)) - longint'($signed(org));
    mag = (d < 0) ? -d : d;
    p = {64'b0, mag} * {96'b0, scl};
    if (d >= 0) f = longint'(p >> 16);
    else f = -longint'((p + 128'd65535) >> 16);
    n = (cells == 0) ? 1 : longint'(cells);
    s = f * n;
    i = s >>> 16;
    if (i < 0) i = 0;
    if (i > n - 1) i = n - 1;
    rem = s - i * 65536;
    if (rem > 64'sd2147483647) rem = 64'sd2147483647;
    if (rem < -64'sd2147483648) rem = -64'sd2147483648;
    idx = 32'(i);
  endfunction

  function automatic blend_t predict_blend(logic [31:0] cx, cy, logic last);
    int unsigned xi, yi, rows;
    int unsigned addr [4];
    longint rx, ry, wl [4];
    logic signed [127:0] acc, t, nv;
    blend_t b;
    locate_axis(cx, org_x, scl_x, cells_w, xi, rx);
    locate_axis(cy, org_y, scl_y, cells_h, yi, ry);
    rows = ((cells_h == 0) ? 1 : cells_h) + 1;
    addr[0] = xi * rows + yi;
    addr[1] = addr[0] + 1;
    addr[2] = addr[0] + rows;
    addr[3] = addr[2] + 1;
    wl[0] = (65536 - rx) * (65536 - ry);
    wl[1] = (65536 - rx) * ry;
    wl[2] = rx * (65536 - ry);
    wl[3] = rx * ry;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        t = wl[k];
        nv = (addr[k] < NODES) ? node_mem[addr[k]][c] : 32'sd0;
        acc = acc + t * nv;
      end
      acc = (acc + (128'sd1 <<< 31)) >>> 32;
      if (acc > 128'sd2147483647) acc = 128'sd2147483647;
      if (acc < -128'sd2147483648) acc = -128'sd2147483648;
      if (c == 0) b.x = acc[31:0];
      else if (c == 1) b.y = acc[31:0];
      else b.z = acc[31:0];
    end
    b.last = last;
    return b;
  endfunction

  always @(posedge clk_i) begin
    blend_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (blend_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word x=%h", interp_x_o);
      end else begin
        e = blend_q.pop_front();
        if (interp_x_o !== e.x || interp_y_o !== e.y || interp_z_o !== e.z ||
            last_result_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b", e.x, e.y, e.z, e.last,
                     interp_x_o, interp_y_o, interp_z_o, last_result_o);
        end
      end
    end
  end

  // result side: random stalls, one long hold-off to back the pipe up
  initial begin
    int hold;
    bit long_done;
    hold = 0;
    long_done = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else if (!long_done && words_sent >= 200) begin
        long_done = 1;
        hold = 299;
        out_ready_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input row_t r);
    blend_t b;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = r.cmd;
    node_index_i = r.idx;
    node_x_i = r.nx;
    node_y_i = r.ny;
    node_z_i = r.nz;
    coord_x_i = r.cx;
    coord_y_i = r.cy;
    last_query_i = r.last;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (r.cmd == CMD_LOAD) begin
      node_mem[r.idx][0] = r.nx;
      node_mem[r.idx][1] = r.ny;
      node_mem[r.idx][2] = r.nz;
    end else if (r.has_exp) begin
      b.x = r.ex; b.y = r.ey; b.z = r.ez; b.last = r.last;
      blend_q.push_back(b);
    end else begin
      blend_q.push_back(predict_blend(r.cx, r.cy, r.last));
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] v);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = v;
    case (idx)
      CFG_ORIGIN_X:   org_x = v;
      CFG_ORIGIN_Y:   org_y = v;
      CFG_SCALE_X:    scl_x = v;
      CFG_SCALE_Y:    scl_y = v;
      CFG_CELLS_WIDE: cells_w = v[5:0];
      default:        cells_h = v[5:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain;
    while (blend_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic row_t rand_row(cmd_e cmd);
    row_t r;
    r.cmd = cmd;
    r.idx = 12'($urandom);
    r.nx = $urandom; r.ny = $urandom; r.nz = $urandom;
    r.cx = $urandom; r.cy = $urandom;
    r.last = 1'($urandom_range(0, 1));
    r.has_exp = 0;
    r.ex = 0; r.ey = 0; r.ez = 0;
    return r;
  endfunction

  function automatic logic [31:0] near_coord(logic [31:0] org, scl);
    longint span, off;
    span = (scl == 0) ? 65536 : longint'(64'h1_0000_0000 / scl);
    if (span > 64'sd1073741824) span = 64'sd1073741824;
    if (span < 4) span = 4;
    off = longint'($urandom_range(0, 32'(span + span / 2))) - span / 4;
    return org + 32'(off);
  endfunction

  task automatic run_phase(input logic [31:0] ox, oy, sx, sy, cw, ch, input int count);
    row_t r;
    int unsigned nodes;
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_SCALE_X, sx);
    cfg_write(CFG_SCALE_Y, sy);
    cfg_write(CFG_CELLS_WIDE, cw);
    cfg_write(CFG_CELLS_HIGH, ch);
    nodes = (((cells_w == 0) ? 1 : cells_w) + 1) * (((cells_h == 0) ? 1 : cells_h) + 1);
    for (int n = 0; n < nodes; n++) begin
      r = rand_row(CMD_LOAD);
      r.idx = 12'(n);
      send_word(r);
    end
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        r = rand_row(CMD_QUERY);
        if ($urandom_range(0, 6) != 0) begin
          r.cx = near_coord(org_x, scl_x);
          r.cy = near_coord(org_y, scl_y);
        end
      end else begin
        r = rand_row(CMD_LOAD);
        if ($urandom_range(0, 4) != 0) r.idx = 12'($urandom_range(0, nodes - 1));
      end
      send_word(r);
    end
    drain();
  endtask

  row_t dir_tab [] = '{
    '{CMD_LOAD,  12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0, 1'b0, 0, 0, 0, 0},
    '{CMD_LOAD,  12'd1, 32'h1, 32'hFFFF_FFFF, 32'h1234_5678, 0, 0, 1'b0, 0, 0, 0, 0},
    '{CMD_LOAD,  12'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b1, 0, 0, 0, 0},
    '{CMD_LOAD,  12'd3, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_8000, 0, 0, 1'b0, 0, 0, 0, 0},
    '{CMD_LOAD,  12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 0, 0, 0},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h0, 32'h0, 1'b0,
      1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h0, 32'h0001_0000, 1'b1,
      1, 32'h1, 32'hFFFF_FFFF, 32'h1234_5678},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h0001_0000, 32'h0, 1'b0,
      1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b1,
      1, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_8000},
    '{CMD_QUERY, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h0000_8000, 32'h0000_8000, 1'b0, 0, 0, 0, 0},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1'b1, 0, 0, 0, 0},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'hFFFF_8000, 32'h0001_8000, 1'b1, 0, 0, 0, 0},
    '{CMD_QUERY, 12'd0, 0, 0, 0, 32'h0003_0000, 32'hFFFD_0000, 1'b0, 0, 0, 0, 0}
  };

  initial begin
    quiet = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ORIGIN_X;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_LOAD;
    node_index_i = '0;
    node_x_i = '0; node_y_i = '0; node_z_i = '0;
    coord_x_i = '0; coord_y_i = '0;
    last_query_i = 1'b0;
    org_x = 0; org_y = 0; scl_x = 32'h1_0000; scl_y = 32'h1_0000;
    cells_w = 6'd1; cells_h = 6'd1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    drain();
    run_phase(32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'd1, 32'd1, 70);
    run_phase(32'h0005_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0002_0000, 32'd4, 32'd3, 80);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd63, 32'd1, 70);
    run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFC1, 32'd63, 70);
    run_phase($urandom, $urandom, 32'h1_0000, 32'h0000_4000, 32'hFFFF_FFC0, 32'd7, 80);
    quiet = 1;
    run_phase(32'h0000_1234, 32'h0, 32'h1_0000, 32'h0003_0000, 32'd8, 32'd8, 90);
    repeat (30) @(posedge clk_i);
    $display("covered %0d input words, %0d results, six register settings", words_sent,
             results_seen);
    $display("loads, queries, clamping, extrapolation, saturation, zero and full scales");
    if (mismatches == 0 && blend_q.size() == 0) begin
      $display("PASS bilinear_grid_interpolator");
    end else begin
      $display("FAIL bilinear_grid_interpolator");
    end
    $finish;
  end
endmodule
